// ===== hw/rtl/lpt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Long-press trigger package
// Shared types, codes and the seconds rounding helper for the long-press
// trigger block.
// ----------------------------------------------------------------------------
package lpt_pkg;

  localparam int unsigned MS_PER_SEC = 1000;

  localparam logic [3:0] NOTHING_SHOWN = 4'd15;
  localparam logic [2:0] COUNT_MAX     = 3'd5;
  localparam logic [2:0] HOLD_MAX      = 3'd2;

  localparam logic [1:0] STATUS_IDLE   = 2'd0;
  localparam logic [1:0] STATUS_CANCEL = 2'd1;
  localparam logic [1:0] STATUS_LAUNCH = 2'd2;

  localparam logic [1:0] KIND_NONE      = 2'd0;
  localparam logic [1:0] KIND_COUNTDOWN = 2'd1;
  localparam logic [1:0] KIND_RELEASE   = 2'd2;
  localparam logic [1:0] KIND_HOLDOFF   = 2'd3;

  localparam logic [1:0] REG_COUNTDOWN_DELAY = 2'd0;
  localparam logic [1:0] REG_TRIGGER_HOLD    = 2'd1;
  localparam logic [1:0] REG_HOLDOFF         = 2'd2;

  localparam logic [15:0] RESET_COUNTDOWN_DELAY = 16'd25000;
  localparam logic [15:0] RESET_TRIGGER_HOLD    = 16'd30000;
  localparam logic [15:0] RESET_HOLDOFF         = 16'd2000;

  typedef struct packed {
    logic [15:0] countdown_delay_ms;
    logic [15:0] trigger_hold_ms;
    logic [15:0] holdoff_ms;
  } cfg_t;

  typedef struct packed {
    logic [31:0] now_time;
    logic        pen_pressed;
  } item_t;

  typedef struct packed {
    logic [1:0] status;
    logic       blocking;
    logic [1:0] overlay_kind;
    logic [3:0] shown_digit;
    logic       redraw;
  } result_t;

  // Ceiling of the remaining milliseconds in seconds, clamped to the cap.
  // Only values up to five seconds are counted, which covers every cap used.
  function automatic logic [3:0] ceil_secs(input logic [15:0] remain_ms,
                                           input logic [2:0]  cap);
    logic [2:0] cnt;
    cnt = 3'd0;
    for (int k = 0; k < 5; k++) begin
      if ({16'd0, remain_ms} > 32'(k) * MS_PER_SEC) begin
        cnt = cnt + 3'd1;
      end
    end
    if (cnt > cap) begin
      cnt = cap;
    end
    return {1'b0, cnt};
  endfunction

endpackage

// ===== hw/rtl/long_press_trigger_fsm_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Long-press trigger unit
// Watches timestamped pen-down ticks, runs the countdown, release and
// hold-off sequence, and reports one result word per tick.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake            Word
// in       input      in_valid/in_ready    now_time, pen_pressed
// out      output     out_valid/out_ready  status, blocking, overlay_kind,
//                                          shown_digit, redraw
// cfg      input      cfg_write            cfg_index, cfg_data
//
// Each word passes through an input register that feeds the state machine,
// which writes the result register; a new word is accepted every cycle
// unless the output is stalled and the input register is full.
// Reset is synchronous and restores the register defaults and idle state.
// A stalled output holds its word while one more input word is buffered.
// ----------------------------------------------------------------------------
module long_press_trigger_fsm_unit
  import lpt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] now_time,
  input  logic        pen_pressed,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic        blocking,
  output logic [1:0]  overlay_kind,
  output logic [3:0]  shown_digit,
  output logic        redraw
);

  cfg_t    cfg;
  item_t   in_item;
  logic    in_full;
  logic    item_take;
  result_t result;

  lpt_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign in_ready = !in_full || item_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full             <= 1'b1;
      in_item.now_time    <= now_time;
      in_item.pen_pressed <= pen_pressed;
    end else if (item_take) begin
      in_full <= 1'b0;
    end
  end

  lpt_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (in_full),
    .item       (in_item),
    .item_take  (item_take),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .result     (result)
  );

  assign status       = result.status;
  assign blocking     = result.blocking;
  assign overlay_kind = result.overlay_kind;
  assign shown_digit  = result.shown_digit;
  assign redraw       = result.redraw;

`ifndef NO_ASSERTIONS
  a_finish_not_blocking: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == STATUS_LAUNCH || status == STATUS_CANCEL) |-> !blocking)
    else $error("finishing status reported while still blocking");

  a_digit_only_with_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && (overlay_kind == KIND_NONE || overlay_kind == KIND_RELEASE)
      |-> shown_digit == 4'd0)
    else $error("digit shown without a digit overlay");

  a_redraw_needs_overlay: assert property (@(posedge clk) disable iff (rst)
    out_valid && redraw |-> overlay_kind != KIND_NONE)
    else $error("redraw requested with no overlay");

  a_take_fills_output: assert property (@(posedge clk) disable iff (rst)
    item_take |=> out_valid)
    else $error("processed word did not reach the result register");

  a_overlay_means_blocking: assert property (@(posedge clk) disable iff (rst)
    out_valid && overlay_kind != KIND_NONE |-> blocking)
    else $error("overlay shown while idle");
`endif

endmodule

// ===== hw/rtl/lpt_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Long-press trigger configuration registers
// Holds the three millisecond settings, written through a plain write port.
// ----------------------------------------------------------------------------
module lpt_cfg
  import lpt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output cfg_t        cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.countdown_delay_ms <= RESET_COUNTDOWN_DELAY;
      cfg.trigger_hold_ms    <= RESET_TRIGGER_HOLD;
      cfg.holdoff_ms         <= RESET_HOLDOFF;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_COUNTDOWN_DELAY: cfg.countdown_delay_ms <= cfg_data;
        REG_TRIGGER_HOLD:    cfg.trigger_hold_ms    <= cfg_data;
        REG_HOLDOFF:         cfg.holdoff_ms         <= cfg_data;
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/lpt_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Long-press trigger core
// Four-state press machine and the result register. One buffered word is
// taken per cycle whenever the result register is free or being drained.
// ----------------------------------------------------------------------------
module lpt_core
  import lpt_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    item_valid,
  input  item_t   item,
  output logic    item_take,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t result
);

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_COUNTDOWN,
    MODE_WAITREL,
    MODE_HOLDOFF
  } mode_t;

  mode_t       mode, mode_next;
  logic [31:0] press_start, press_start_next;
  logic [31:0] release_time, release_time_next;
  logic [3:0]  last_shown, last_shown_next;
  result_t     result_next;

  assign item_take = item_valid && (!out_valid || out_ready);

  always_comb begin
    logic [31:0] start_use;
    logic [31:0] held;
    logic [31:0] elapsed;
    logic [15:0] remain;
    logic [3:0]  digit;

    mode_next         = mode;
    press_start_next  = press_start;
    release_time_next = release_time;
    last_shown_next   = last_shown;
    result_next       = '0;
    start_use         = (press_start == 32'd0) ? item.now_time : press_start;
    held              = item.now_time - press_start;
    elapsed           = item.now_time - release_time;
    remain            = 16'd0;
    digit             = 4'd0;

    case (mode)
      MODE_IDLE: begin
        if (item.pen_pressed) begin
          press_start_next = start_use;
          if (item.now_time - start_use >= {16'd0, cfg.countdown_delay_ms}) begin
            mode_next       = MODE_COUNTDOWN;
            last_shown_next = NOTHING_SHOWN;
          end
        end else begin
          press_start_next = 32'd0;
        end
      end
      MODE_COUNTDOWN: begin
        if (!item.pen_pressed) begin
          mode_next          = MODE_IDLE;
          press_start_next   = 32'd0;
          last_shown_next    = NOTHING_SHOWN;
          result_next.status = STATUS_CANCEL;
        end else if (held < {16'd0, cfg.trigger_hold_ms}) begin
          remain                   = cfg.trigger_hold_ms - held[15:0];
          digit                    = ceil_secs(remain, COUNT_MAX);
          result_next.overlay_kind = KIND_COUNTDOWN;
          result_next.shown_digit  = digit;
          if (digit != last_shown) begin
            last_shown_next    = digit;
            result_next.redraw = 1'b1;
          end
        end else begin
          mode_next                = MODE_WAITREL;
          last_shown_next          = NOTHING_SHOWN;
          result_next.overlay_kind = KIND_RELEASE;
          result_next.redraw       = 1'b1;
        end
      end
      MODE_WAITREL: begin
        if (!item.pen_pressed) begin
          release_time_next        = item.now_time;
          mode_next                = MODE_HOLDOFF;
          last_shown_next          = {1'b0, HOLD_MAX};
          result_next.overlay_kind = KIND_HOLDOFF;
          result_next.shown_digit  = {1'b0, HOLD_MAX};
          result_next.redraw       = 1'b1;
        end else begin
          result_next.overlay_kind = KIND_RELEASE;
        end
      end
      MODE_HOLDOFF: begin
        if (elapsed >= {16'd0, cfg.holdoff_ms}) begin
          mode_next          = MODE_IDLE;
          press_start_next   = 32'd0;
          result_next.status = STATUS_LAUNCH;
        end else begin
          remain                   = cfg.holdoff_ms - elapsed[15:0];
          digit                    = ceil_secs(remain, HOLD_MAX);
          result_next.overlay_kind = KIND_HOLDOFF;
          result_next.shown_digit  = digit;
          if (digit != last_shown) begin
            last_shown_next    = digit;
            result_next.redraw = 1'b1;
          end
        end
      end
      default: begin
        mode_next = MODE_IDLE;
      end
    endcase

    result_next.blocking = (mode_next != MODE_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_IDLE;
      press_start  <= 32'd0;
      release_time <= 32'd0;
      last_shown   <= NOTHING_SHOWN;
      out_valid    <= 1'b0;
    end else if (item_take) begin
      mode         <= mode_next;
      press_start  <= press_start_next;
      release_time <= release_time_next;
      last_shown   <= last_shown_next;
      result       <= result_next;
      out_valid    <= 1'b1;
    end else if (out_ready) begin
      out_valid    <= 1'b0;
    end
  end

endmodule
